@@ design/sbpe_pkg.sv @@
// shared types and constants for the sobel/prewitt edge threshold block
// no dependencies

package sbpe_pkg;

    localparam int PIX_W     = 8;
    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 12;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;
    localparam int WORD_W    = 2 * PIX_W;
    localparam int Q_DEPTH   = 4;
    localparam int QA_W      = 2;
    localparam int QC_W      = 3;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam logic [IMG_W_W-1:0] RST_IMG_W = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0] RST_IMG_H = IMG_H_W'(480);
    localparam logic [PIX_W-1:0]   RST_THR   = PIX_W'(128);
    localparam logic               RST_MODE  = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE    = 2'd3;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // window taps, row-major, index 8 is the newest pixel
    typedef logic [8:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic             drain;
        logic [PIX_W-1:0] px;
        logic             emit;
        logic             border;
        logic             row_end;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] col2;
        logic             eof;
    } t_s1;

    typedef struct packed {
        logic [PIX_W-1:0] edge_out;
        logic [PIX_W-1:0] mag;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             eof;
    } t_res;

endpackage

@@ design/sbpe_grad.sv @@
// 3x3 gradient magnitude |gx|+|gy| saturated to 8 bits, sobel or prewitt
// depends on sbpe_pkg

module sbpe_grad (
    input  sbpe_pkg::t_win                i_win,
    input  logic                          i_sobel,
    output logic [sbpe_pkg::PIX_W-1:0]    o_mag
);

    logic signed [11:0] p0, p1, p2, p3, p5, p6, p7, p8;
    logic signed [11:0] sx, cx, sy, cy, gx, gy;
    logic [10:0]        ax, ay;
    logic [11:0]        sum;

    always_comb begin
        p0 = $signed({4'b0, i_win[0]});
        p1 = $signed({4'b0, i_win[1]});
        p2 = $signed({4'b0, i_win[2]});
        p3 = $signed({4'b0, i_win[3]});
        p5 = $signed({4'b0, i_win[5]});
        p6 = $signed({4'b0, i_win[6]});
        p7 = $signed({4'b0, i_win[7]});
        p8 = $signed({4'b0, i_win[8]});
        sx = (p2 + p8) - (p0 + p6);
        cx = p5 - p3;
        sy = (p6 + p8) - (p0 + p2);
        cy = p7 - p1;
        gx = sx + (i_sobel ? (cx <<< 1) : cx);
        gy = sy + (i_sobel ? (cy <<< 1) : cy);
        ax = gx[11] ? 11'(-gx) : gx[10:0];
        ay = gy[11] ? 11'(-gy) : gy[10:0];
        sum = {1'b0, ax} + {1'b0, ay};
        o_mag = (sum > 12'd255) ? sbpe_pkg::PIX_MAX : sum[7:0];
    end

endmodule

@@ design/sbpe_linemem.sv @@
// two line stores packed into one word memory, older row in the high byte
// registered read, one write port, zero-fill sweep after reset; uses sbpe_pkg

module sbpe_linemem #(
    parameter int MAX_WIDTH = sbpe_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    output logic [sbpe_pkg::WORD_W-1:0]   o_rd_data,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_wr_addr,
    input  logic [sbpe_pkg::WORD_W-1:0]   i_wr_data,
    output logic                          o_busy
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [sbpe_pkg::WORD_W-1:0] r_mem [MAX_WIDTH];
    logic [sbpe_pkg::WORD_W-1:0] r_rd_data;
    logic                        r_busy;
    logic [AW-1:0]               r_clr_addr;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [sbpe_pkg::WORD_W-1:0] wdata;

    always_comb begin
        we    = r_busy || i_wr_en;
        waddr = r_busy ? r_clr_addr : i_wr_addr;
        wdata = r_busy ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == AW'(MAX_WIDTH - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

@@ design/sobel_prewitt_edge_threshold.sv @@
// top level of the streaming 3x3 sobel/prewitt edge detector with threshold
// depends on sbpe_pkg, sbpe_linemem, sbpe_grad
//
// usage:
//   input channel i_valid/o_ready carries one item: a gray pixel in raster
//   order (i_req_type = pixel) or a drain request that flushes one pixel of
//   the final row after the frame's last pixel. output channel
//   o_valid/i_ready carries result pixels with their row and column.
//   configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data).
//   throughput: one item per cycle while the result queue has room; the last
//   pixel of each row makes two results, which can stall the input.
//   pipeline: an accepted item passes the stage 1 register, then its results
//   enter the result queue; pixel (r,c) reports pixel (r-1,c-1).
//   reset: synchronous, active low; afterwards o_ready stays low while
//   every word of the line store is swept to zero.
//   a stalled receiver fills a four-entry result queue; o_ready drops once
//   fewer than two free slots would remain after the item in flight.

module sobel_prewitt_edge_threshold #(
    parameter int MAX_WIDTH = sbpe_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sbpe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sbpe_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_req_type,
    input  logic [sbpe_pkg::PIX_W-1:0]        i_pixel_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [sbpe_pkg::PIX_W-1:0]        o_edge_out,
    output logic [sbpe_pkg::PIX_W-1:0]        o_magnitude,
    output logic [sbpe_pkg::ROW_W-1:0]        o_out_row,
    output logic [sbpe_pkg::COL_W-1:0]        o_out_col,
    output logic                              o_last_of_run,
    output logic                              o_end_of_frame
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW0 = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (WW0 > sbpe_pkg::IMG_W_W) ? WW0 : sbpe_pkg::IMG_W_W;
    localparam int RW  = sbpe_pkg::ROW_W;
    localparam int CW  = sbpe_pkg::COL_W;
    localparam int PW  = sbpe_pkg::PIX_W;

    // configuration
    logic [sbpe_pkg::IMG_W_W-1:0] r_img_w;
    logic [sbpe_pkg::IMG_H_W-1:0] r_img_h;
    logic [PW-1:0]                r_thr;
    logic                         r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= sbpe_pkg::RST_IMG_W;
            r_img_h <= sbpe_pkg::RST_IMG_H;
            r_thr   <= sbpe_pkg::RST_THR;
            r_mode  <= sbpe_pkg::RST_MODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sbpe_pkg::CFG_IMAGE_WIDTH: begin
                    r_img_w <= i_cfg_data[sbpe_pkg::IMG_W_W-1:0];
                end
                sbpe_pkg::CFG_IMAGE_HEIGHT: begin
                    r_img_h <= i_cfg_data[sbpe_pkg::IMG_H_W-1:0];
                end
                sbpe_pkg::CFG_EDGE_THRESHOLD: begin
                    r_thr <= i_cfg_data[PW-1:0];
                end
                sbpe_pkg::CFG_KERNEL_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // frame position
    logic [RW-1:0] r_row;
    logic [WW-1:0] r_col;
    logic [WW-1:0] r_drain;

    logic [WW-1:0] w_ext, w_eff, wm1;
    logic [RW-1:0] h_eff, hm1;
    logic          draining, is_drain, eff_item, accept, go;
    logic          row_end, drain_eof, emit, border;
    logic [RW-1:0] rr;
    logic [WW-1:0] cc;
    logic [AW-1:0] rd_addr;
    sbpe_pkg::t_s1 n_s1;

    always_comb begin
        w_ext = WW'(r_img_w);
        if (w_ext < WW'(3)) begin
            w_eff = WW'(3);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        wm1   = w_eff - WW'(1);
        h_eff = (r_img_h < RW'(3)) ? RW'(3) : r_img_h;
        hm1   = h_eff - RW'(1);

        draining  = r_row >= h_eff;
        is_drain  = (i_req_type == sbpe_pkg::REQ_DRAIN);
        eff_item  = is_drain ? draining : !draining;
        accept    = i_valid && o_ready;
        go        = accept && eff_item;

        row_end   = r_col >= wm1;
        drain_eof = r_drain >= wm1;
        emit      = (r_row != '0) && (r_col != '0);
        rr        = r_row - RW'(1);
        cc        = r_col - WW'(1);
        border    = (rr == '0) || (rr >= hm1) || (cc == '0) || (cc >= wm1);

        rd_addr   = is_drain ? r_drain[AW-1:0] : r_col[AW-1:0];

        n_s1.drain   = is_drain;
        n_s1.px      = i_pixel_in;
        n_s1.emit    = emit;
        n_s1.border  = border;
        n_s1.row_end = row_end;
        n_s1.row     = is_drain ? hm1 : rr;
        n_s1.col     = cc[CW-1:0];
        n_s1.col2    = is_drain ? r_drain[CW-1:0] : r_col[CW-1:0];
        n_s1.eof     = is_drain && drain_eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_drain <= '0;
        end else if (go) begin
            if (is_drain) begin
                if (drain_eof) begin
                    r_row   <= '0;
                    r_col   <= '0;
                    r_drain <= '0;
                end else begin
                    r_drain <= r_drain + WW'(1);
                end
            end else if (row_end) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + WW'(1);
            end
        end
    end

    // stage 1: line store data and window
    logic          r_s1_vld;
    sbpe_pkg::t_s1 r_s1;
    logic [AW-1:0] r_s1_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1      <= n_s1;
            r_s1_addr <= rd_addr;
        end
    end

    logic [sbpe_pkg::WORD_W-1:0] rd_data;
    logic                        mem_busy;
    logic                        mem_we;
    logic [PW-1:0]               q_older, q_prev;

    assign q_older = rd_data[2*PW-1:PW];
    assign q_prev  = rd_data[PW-1:0];
    assign mem_we  = r_s1_vld && !r_s1.drain;

    sbpe_linemem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linemem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({q_prev, r_s1.px}),
        .o_busy    (mem_busy)
    );

    sbpe_pkg::t_win r_win;
    sbpe_pkg::t_win win_new;
    logic [PW-1:0]  grad_mag;

    always_comb begin
        win_new[0] = r_win[1];
        win_new[1] = r_win[2];
        win_new[2] = q_older;
        win_new[3] = r_win[4];
        win_new[4] = r_win[5];
        win_new[5] = q_prev;
        win_new[6] = r_win[7];
        win_new[7] = r_win[8];
        win_new[8] = r_s1.px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (mem_we) begin
            r_win <= win_new;
        end
    end

    sbpe_grad u_grad (
        .i_win   (win_new),
        .i_sobel (r_mode),
        .o_mag   (grad_mag)
    );

    sbpe_pkg::t_res res_a, res_b;
    logic [1:0]     push_n;

    always_comb begin
        if (r_s1.drain) begin
            res_a.mag  = q_prev;
            res_a.col  = r_s1.col2;
            res_a.last = 1'b1;
            res_a.eof  = r_s1.eof;
        end else begin
            res_a.mag  = r_s1.border ? win_new[4] : grad_mag;
            res_a.col  = r_s1.col;
            res_a.last = !r_s1.row_end;
            res_a.eof  = 1'b0;
        end
        res_a.row      = r_s1.row;
        res_a.edge_out = (res_a.mag > r_thr) ? sbpe_pkg::PIX_MAX : '0;

        res_b.mag      = q_prev;
        res_b.row      = r_s1.row;
        res_b.col      = r_s1.col2;
        res_b.last     = 1'b1;
        res_b.eof      = 1'b0;
        res_b.edge_out = (res_b.mag > r_thr) ? sbpe_pkg::PIX_MAX : '0;

        if (!r_s1_vld) begin
            push_n = 2'd0;
        end else if (r_s1.drain) begin
            push_n = 2'd1;
        end else if (r_s1.emit) begin
            push_n = r_s1.row_end ? 2'd2 : 2'd1;
        end else begin
            push_n = 2'd0;
        end
    end

    // result queue
    sbpe_pkg::t_res                 r_q [sbpe_pkg::Q_DEPTH];
    logic [sbpe_pkg::QA_W-1:0]      r_wr, r_rd;
    logic [sbpe_pkg::QC_W-1:0]      r_cnt;
    logic                           pop;
    logic [sbpe_pkg::QC_W:0]        room_need;

    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + sbpe_pkg::QA_W'(push_n);
            r_rd  <= r_rd + sbpe_pkg::QA_W'(pop);
            r_cnt <= r_cnt + sbpe_pkg::QC_W'(push_n) - sbpe_pkg::QC_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wr] <= res_a;
        end
        if (push_n == 2'd2) begin
            r_q[r_wr + sbpe_pkg::QA_W'(1)] <= res_b;
        end
    end

    always_comb begin
        room_need = {1'b0, r_cnt} + (sbpe_pkg::QC_W + 1)'(push_n)
                  + (sbpe_pkg::QC_W + 1)'(2);
        o_ready   = !mem_busy && (room_need <= (sbpe_pkg::QC_W + 1)'(sbpe_pkg::Q_DEPTH));
    end

    assign o_valid        = (r_cnt != '0);
    assign o_edge_out     = r_q[r_rd].edge_out;
    assign o_magnitude    = r_q[r_rd].mag;
    assign o_out_row      = r_q[r_rd].row;
    assign o_out_col      = r_q[r_rd].col;
    assign o_last_of_run  = r_q[r_rd].last;
    assign o_end_of_frame = r_q[r_rd].eof;

endmodule

@@ tb/sbpe_edge_checker.sv @@
// result checker for sobel_prewitt_edge_threshold: follows the item, result and register
// ports, keeps its own line stores and 3x3 window, queues the thresholded pixels and
// compares them in order with what the block delivers. depends on sbpe_pkg

module sbpe_edge_checker
    import sbpe_pkg::*;
#(
    parameter int MAX_W = MAX_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_req_type,
    input  logic [PIX_W-1:0]     i_pixel_in,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [PIX_W-1:0]     i_edge_out,
    input  logic [PIX_W-1:0]     i_magnitude,
    input  logic [ROW_W-1:0]     i_out_row,
    input  logic [COL_W-1:0]     i_out_col,
    input  logic                 i_last_of_run,
    input  logic                 i_end_of_frame,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PIX_W-1:0]   line_prev  [MAX_W];
    logic [PIX_W-1:0]   line_older [MAX_W];
    logic [PIX_W-1:0]   win        [9];
    int                 row_cnt;
    int                 col_cnt;
    int                 drain_cnt;
    logic [IMG_W_W-1:0] cfg_width;
    logic [IMG_H_W-1:0] cfg_height;
    logic [PIX_W-1:0]   cfg_thr;
    logic               cfg_sobel;
    t_res               thresholded_q [$];
    int                 err_cnt;

    function automatic void push_result(input int mag, input int row, input int col,
                                        input logic last, input logic eof);
        t_res r;
        r.edge_out = (mag > int'(cfg_thr)) ? PIX_MAX : '0;
        r.mag      = mag[PIX_W-1:0];
        r.row      = row[ROW_W-1:0];
        r.col      = col[COL_W-1:0];
        r.last     = last;
        r.eof      = eof;
        thresholded_q = {thresholded_q, r};
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic filter_item(input logic req, input logic [PIX_W-1:0] px);
        int   w, h, c, rr, cc, mag, gx, gy, cx, cy;
        logic row_end, border, eof;
        w = (cfg_width < 3) ? 3 : (cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
        h = (cfg_height < 3) ? 3 : int'(cfg_height);
        if (req == REQ_DRAIN) begin
            if (row_cnt >= h) begin
                eof = (drain_cnt >= w - 1);
                push_result(int'(line_prev[drain_cnt % MAX_W]), h - 1, drain_cnt, 1'b1, eof);
                if (eof) begin
                    row_cnt   = 0;
                    col_cnt   = 0;
                    drain_cnt = 0;
                end else begin
                    drain_cnt++;
                end
            end
        end else if (row_cnt < h) begin
            c       = col_cnt % MAX_W;
            row_end = (col_cnt >= w - 1);
            for (int i = 0; i < 3; i++) begin
                win[i*3]   = win[i*3+1];
                win[i*3+1] = win[i*3+2];
            end
            win[2]        = line_older[c];
            win[5]        = line_prev[c];
            win[8]        = px;
            line_older[c] = line_prev[c];
            line_prev[c]  = px;
            if (row_cnt >= 1 && col_cnt >= 1) begin
                rr     = row_cnt - 1;
                cc     = col_cnt - 1;
                border = (rr == 0) || (rr >= h - 1) || (cc == 0) || (cc >= w - 1);
                if (border) begin
                    mag = int'(win[4]);
                end else begin
                    gx = 0;
                    gy = 0;
                    // sobel doubles the center row of gx and the center column of gy
                    for (int i = 0; i < 9; i++) begin
                        cx = i % 3 - 1;
                        cy = i / 3 - 1;
                        gx += ((cfg_sobel && cy == 0) ? 2 * cx : cx) * int'(win[i]);
                        gy += ((cfg_sobel && cx == 0) ? 2 * cy : cy) * int'(win[i]);
                    end
                    if (gx < 0) gx = -gx;
                    if (gy < 0) gy = -gy;
                    mag = (gx + gy > 255) ? 255 : gx + gy;
                end
                push_result(mag, rr, cc, !row_end, 1'b0);
                if (row_end) push_result(int'(win[5]), rr, col_cnt, 1'b1, 1'b0);
            end
            if (row_end) begin
                col_cnt = 0;
                row_cnt++;
            end else begin
                col_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_W; i++) begin
                line_prev[i]  = '0;
                line_older[i] = '0;
            end
            for (int i = 0; i < 9; i++) win[i] = '0;
            row_cnt    = 0;
            col_cnt    = 0;
            drain_cnt  = 0;
            cfg_width  = RST_IMG_W;
            cfg_height = RST_IMG_H;
            cfg_thr    = RST_THR;
            cfg_sobel  = RST_MODE;
            thresholded_q.delete();
            err_cnt    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:    cfg_width  = i_cfg_data[IMG_W_W-1:0];
                    CFG_IMAGE_HEIGHT:   cfg_height = i_cfg_data[IMG_H_W-1:0];
                    CFG_EDGE_THRESHOLD: cfg_thr    = i_cfg_data[PIX_W-1:0];
                    CFG_KERNEL_MODE:    cfg_sobel  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) filter_item(i_req_type, i_pixel_in);
            if (i_res_valid && i_res_ready) begin
                if (thresholded_q.size() == 0) begin
                    $error("unexpected result at row %0d col %0d", i_out_row, i_out_col);
                    err_cnt++;
                end else begin
                    want = thresholded_q.pop_front();
                    check_field("edge_out", int'(want.edge_out), int'(i_edge_out));
                    check_field("magnitude", int'(want.mag), int'(i_magnitude));
                    check_field("out_row", int'(want.row), int'(i_out_row));
                    check_field("out_col", int'(want.col), int'(i_out_col));
                    check_field("last_of_run", int'(want.last), int'(i_last_of_run));
                    check_field("end_of_frame", int'(want.eof), int'(i_end_of_frame));
                end
            end
        end
        o_pending <= thresholded_q.size();
        o_errors  <= err_cnt;
    end

endmodule

@@ tb/tb_sobel_prewitt_edge_threshold.sv @@
// top of the sobel_prewitt_edge_threshold testbench: clock, reset, register writes,
// pixel and drain stimulus under several idle patterns, watchdog and verdict.
// depends on sbpe_pkg, sbpe_edge_checker and the block itself

module tb_sobel_prewitt_edge_threshold
    import sbpe_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 240;

    typedef enum int {PAT_NOISE, PAT_EXTREME, PAT_RAMP, PAT_STEP} t_pattern;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 i_valid    = 1'b0;
    logic                 o_ready;
    logic                 i_req_type = REQ_PIXEL;
    logic [PIX_W-1:0]     i_pixel_in = '0;
    logic                 o_valid;
    logic                 i_ready    = 1'b1;
    logic [PIX_W-1:0]     o_edge_out;
    logic [PIX_W-1:0]     o_magnitude;
    logic [ROW_W-1:0]     o_out_row;
    logic [COL_W-1:0]     o_out_col;
    logic                 o_last_of_run;
    logic                 o_end_of_frame;

    int chk_errors;
    int chk_pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int items_sent     = 0;

    sobel_prewitt_edge_threshold dut (.*);

    sbpe_edge_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_req_type     (i_req_type),
        .i_pixel_in     (i_pixel_in),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_edge_out     (o_edge_out),
        .i_magnitude    (o_magnitude),
        .i_out_row      (o_out_row),
        .i_out_col      (o_out_col),
        .i_last_of_run  (o_last_of_run),
        .i_end_of_frame (o_end_of_frame),
        .o_errors       (chk_errors),
        .o_pending      (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_sobel_prewitt_edge_threshold failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic req, input logic [PIX_W-1:0] px);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_pixel_in <= px;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // hold the input until every queued result has been taken
    task automatic wait_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input int wd, input int hd, input int td, input int md);
        wait_quiet();
        write_reg(CFG_IMAGE_WIDTH, CFG_DAT_W'(wd));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DAT_W'(hd));
        write_reg(CFG_EDGE_THRESHOLD, CFG_DAT_W'(td));
        write_reg(CFG_KERNEL_MODE, CFG_DAT_W'(md));
    endtask

    task automatic stream_frame(input int w, input int h, input t_pattern pat);
        int               r, c;
        logic [PIX_W-1:0] px;
        if ($urandom_range(3) == 0) send_item(REQ_DRAIN, PIX_W'($urandom_range(255)));
        for (r = 0; r < h; r++) begin
            for (c = 0; c < w; c++) begin
                case (pat)
                    PAT_NOISE:   px = PIX_W'($urandom_range(255));
                    PAT_EXTREME: px = $urandom_range(1) ? PIX_MAX : '0;
                    PAT_RAMP:    px = PIX_W'(r * 24 + c * 9 + $urandom_range(7));
                    default:     px = (c < w / 2) ? PIX_W'($urandom_range(40))
                                                  : PIX_W'(200 + $urandom_range(55));
                endcase
                send_item(REQ_PIXEL, px);
            end
            if (r < h - 1 && $urandom_range(9) == 0) begin
                wait_quiet();
            end else if ($urandom_range(19) == 0) begin
                send_item(REQ_DRAIN, PIX_W'($urandom_range(255)));
            end
        end
        if ($urandom_range(2) == 0) send_item(REQ_PIXEL, PIX_W'($urandom_range(255)));
        repeat (w) send_item(REQ_DRAIN, PIX_W'($urandom_range(255)));
    endtask

    initial begin
        int wd, hd, td, md, w, h, phase_start;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);

        // smallest frame, sobel, threshold that nothing can exceed
        set_frame(0, 0, 255, 1);
        send_item(REQ_DRAIN, PIX_MAX);
        for (int i = 0; i < 9; i++) send_item(REQ_PIXEL, (i % 3 == 2) ? PIX_MAX : '0);
        send_item(REQ_PIXEL, PIX_MAX);
        repeat (3) send_item(REQ_DRAIN, '0);

        // prewitt, zero threshold, checkerboard
        set_frame(3, 3, 0, 0);
        for (int i = 0; i < 9; i++) send_item(REQ_PIXEL, (i % 2 == 1) ? PIX_MAX : '0);
        repeat (3) send_item(REQ_DRAIN, PIX_MAX);

        // width shrinks in the middle of a row
        set_frame(8, 4, 100, 1);
        repeat (13) send_item(REQ_PIXEL, PIX_W'($urandom_range(255)));
        wait_quiet();
        write_reg(CFG_IMAGE_WIDTH, CFG_DAT_W'(3));
        repeat (7) send_item(REQ_PIXEL, PIX_W'($urandom_range(255)));
        repeat (3) send_item(REQ_DRAIN, PIX_W'($urandom_range(255)));

        // tallest frame cut short by a smaller height
        set_frame(0, 4095, $urandom_range(255), 0);
        repeat (12) send_item(REQ_PIXEL, PIX_W'($urandom_range(255)));
        wait_quiet();
        write_reg(CFG_IMAGE_HEIGHT, CFG_DAT_W'(3));
        send_item(REQ_PIXEL, PIX_W'($urandom_range(255)));
        repeat (3) send_item(REQ_DRAIN, PIX_W'($urandom_range(255)));

        // oversized width register, then the row is cut short by a smaller width
        set_frame(12'h7FF, 3, $urandom_range(255), $urandom_range(1));
        repeat (20) send_item(REQ_PIXEL, PIX_W'($urandom_range(255)));
        wait_quiet();
        write_reg(CFG_IMAGE_WIDTH, CFG_DAT_W'(5));
        repeat (11) send_item(REQ_PIXEL, PIX_W'($urandom_range(255)));
        repeat (5) send_item(REQ_DRAIN, PIX_W'($urandom_range(255)));

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                case ($urandom_range(9))
                    0:       wd = $urandom_range(2);
                    1:       wd = 12'h800 | $urandom_range(3, 12);
                    default: wd = $urandom_range(3, 12);
                endcase
                w  = ((wd & 12'h7FF) < 3) ? 3 : (wd & 12'h7FF);
                hd = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 7);
                h  = (hd < 3) ? 3 : hd;
                case ($urandom_range(5))
                    0:       td = 0;
                    1:       td = 255;
                    default: td = $urandom_range(255);
                endcase
                td = td | ($urandom_range(15) << 8);
                md = $urandom_range(1) | ($urandom_range(2047) << 1);
                set_frame(wd, hd, td, md);
                stream_frame(w, h, t_pattern'($urandom_range(3)));
            end
        end

        wait_quiet();
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("tb_sobel_prewitt_edge_threshold passed");
        end else begin
            $display("tb_sobel_prewitt_edge_threshold failed");
        end
        $finish;
    end

endmodule
